// ----- design/sdfg_pkg.sv -----
// Shared types, constants and step functions of the source-detector falloff gain block.
`default_nettype none

package sdfg_pkg;

    localparam int COORD_W         = 24;
    localparam int COORD_FRAC_BITS = 12;
    localparam int MAG_W           = COORD_W + 1;
    localparam int DIFF_W          = COORD_W + 2;
    localparam int SQ_W            = 2 * MAG_W;
    localparam int PHW_W           = 23;
    localparam int COEF_W          = 32;
    localparam int GAIN_W          = 32;
    localparam int PATH_W          = 26;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 32;
    localparam logic signed [COEF_W-1:0] OFFSET_RESET = 32'sd65536;

    // floor square root of a 52 bit radicand, two result bits per stage
    localparam int SQRT_IN_W   = 52;
    localparam int SQRT_OUT_W  = 26;
    localparam int SQRT_REM_W  = SQRT_OUT_W + 2;
    localparam int SQRT_STAGES = SQRT_OUT_W / 2;

    // quotient 2^40 / D16, two quotient bits per stage
    localparam int DVS_W      = 41;
    localparam int DIV_STAGES = GAIN_W / 2;
    localparam int NUM_W      = 88;
    localparam int D16_W      = 64;

    localparam int PIPE_STAGES = 3 + SQRT_STAGES + 3 + SQRT_STAGES + 5 + DIV_STAGES + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROBE_HALF_WIDTH  = 2'd0,
        CFG_FALLOFF_QUADRATIC = 2'd1,
        CFG_FALLOFF_LINEAR    = 2'd2,
        CFG_FALLOFF_OFFSET    = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        GAIN_QUOT = 2'd0,
        GAIN_FULL = 2'd1,
        GAIN_NONE = 2'd2
    } gain_kind_t;

    typedef struct packed {
        logic [SQRT_IN_W-1:0]  rad;
        logic [SQRT_REM_W-1:0] rem;
        logic [SQRT_OUT_W-1:0] root;
    } sqs_t;

    typedef struct packed {
        logic [MAG_W-1:0]     rd1;
        logic [MAG_W-1:0]     rd2;
        logic [SQ_W-1:0]      sq_dy;
        logic [SQRT_IN_W-1:0] rstr;
        logic                 ar;
    } sba_t;

    typedef struct packed {
        logic [DVS_W-1:0]  rem;
        logic [GAIN_W-1:0] q;
        logic [DVS_W-1:0]  dvs;
        gain_kind_t        kind;
        logic [PATH_W-1:0] d;
        logic              ar;
    } divs_t;

    function automatic logic [MAG_W-1:0] mag(input logic signed [DIFF_W-1:0] v);
        logic signed [DIFF_W-1:0] n;
        n = -v;
        return v[DIFF_W-1] ? n[MAG_W-1:0] : v[MAG_W-1:0];
    endfunction

    // one digit of the restoring square root
    function automatic sqs_t sqrt_step(input sqs_t s);
        logic [SQRT_REM_W+1:0] tmp;
        logic [SQRT_REM_W+1:0] trial;
        logic [SQRT_REM_W+1:0] diff;
        sqs_t r;
        tmp   = {s.rem, s.rad[SQRT_IN_W-1 -: 2]};
        trial = {2'b00, s.root, 2'b01};
        diff  = tmp - trial;
        r.rad = {s.rad[SQRT_IN_W-3:0], 2'b00};
        if (tmp >= trial)
        begin
            r.rem  = diff[SQRT_REM_W-1:0];
            r.root = {s.root[SQRT_OUT_W-2:0], 1'b1};
        end
        else
        begin
            r.rem  = tmp[SQRT_REM_W-1:0];
            r.root = {s.root[SQRT_OUT_W-2:0], 1'b0};
        end
        return r;
    endfunction

    // one quotient bit; the dividend bits below the start remainder are all zero
    function automatic divs_t div_step(input divs_t s);
        logic [DVS_W:0] t;
        logic [DVS_W:0] diff;
        divs_t r;
        r    = s;
        t    = {s.rem, 1'b0};
        diff = t - {1'b0, s.dvs};
        if (t >= {1'b0, s.dvs})
        begin
            r.rem = diff[DVS_W-1:0];
            r.q   = {s.q[GAIN_W-2:0], 1'b1};
        end
        else
        begin
            r.rem = t[DVS_W-1:0];
            r.q   = {s.q[GAIN_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- design/sdfg_in_if.sv -----
// Input channel: one source and detector position pair per item.
`default_nettype none

interface sdfg_in_if;
    logic valid;
    logic ready;
    logic signed [sdfg_pkg::COORD_W-1:0] source_x;
    logic signed [sdfg_pkg::COORD_W-1:0] source_y;
    logic signed [sdfg_pkg::COORD_W-1:0] source_z;
    logic signed [sdfg_pkg::COORD_W-1:0] detector_x;
    logic signed [sdfg_pkg::COORD_W-1:0] detector_y;
    logic signed [sdfg_pkg::COORD_W-1:0] detector_z;

    modport source (output valid, source_x, source_y, source_z,
                    detector_x, detector_y, detector_z, input ready);
    modport sink   (input valid, source_x, source_y, source_z,
                    detector_x, detector_y, detector_z, output ready);
endinterface

`default_nettype wire

// ----- design/sdfg_out_if.sv -----
// Output channel: one gain result per item.
`default_nettype none

interface sdfg_out_if;
    logic valid;
    logic ready;
    logic [sdfg_pkg::GAIN_W-1:0] gain;
    logic [sdfg_pkg::PATH_W-1:0] path_length;
    logic                        around_probe;
    logic                        saturated;

    modport source (output valid, gain, path_length, around_probe, saturated, input ready);
    modport sink   (input valid, gain, path_length, around_probe, saturated, output ready);
endinterface

`default_nettype wire

// ----- design/sdfg_isqrt.sv -----
// Pipelined floor square root, two root bits per stage.
`default_nettype none

module sdfg_isqrt (
    input  wire logic                            clk,
    input  wire logic                            en,
    input  wire logic [sdfg_pkg::SQRT_IN_W-1:0]  rad,
    output logic      [sdfg_pkg::SQRT_OUT_W-1:0] root
);

    sdfg_pkg::sqs_t stage_reg  [sdfg_pkg::SQRT_STAGES];
    sdfg_pkg::sqs_t stage_next [sdfg_pkg::SQRT_STAGES];
    sdfg_pkg::sqs_t stage_prev [sdfg_pkg::SQRT_STAGES];

    for (genvar s = 0; s < sdfg_pkg::SQRT_STAGES; s++)
    begin : g_stage
        if (s == 0)
        begin : g_first
            assign stage_prev[s] = '{rad: rad, rem: '0, root: '0};
        end
        else
        begin : g_rest
            assign stage_prev[s] = stage_reg[s-1];
        end
        assign stage_next[s] = sdfg_pkg::sqrt_step(sdfg_pkg::sqrt_step(stage_prev[s]));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                stage_reg[s] <= stage_next[s];
            end
        end
    end

    assign root = stage_reg[sdfg_pkg::SQRT_STAGES-1].root;

endmodule

`default_nettype wire

// ----- design/source_detector_falloff_gain_core.sv -----
// One item per cycle sustained while the output register is empty or being taken.
// Path: 3 geometry stages, 13-stage square root, 3 stages, second 13-stage square
// root, 5 falloff polynomial stages, 16-stage reciprocal divider, output register.
// The whole pipe advances when the output register is empty or being taken.
// rst_n (async, low) clears valid bits and loads register reset values.
`default_nettype none

module source_detector_falloff_gain_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [sdfg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [sdfg_pkg::CFG_DATA_W-1:0] cfg_data,
    sdfg_in_if.sink                              pos,
    sdfg_out_if.source                           res
);

    localparam int MW = sdfg_pkg::MAG_W;
    localparam int DW = sdfg_pkg::DIFF_W;
    localparam int SW = sdfg_pkg::SQ_W;
    localparam int RW = sdfg_pkg::SQRT_IN_W;
    localparam int PW = sdfg_pkg::PATH_W;
    localparam int NW = sdfg_pkg::NUM_W;
    localparam int F  = sdfg_pkg::COORD_FRAC_BITS;

    // ---------------- configuration registers ----------------
    logic        [sdfg_pkg::PHW_W-1:0]  phw_reg;
    logic signed [sdfg_pkg::COEF_W-1:0] quad_reg;
    logic signed [sdfg_pkg::COEF_W-1:0] lin_reg;
    logic signed [sdfg_pkg::COEF_W-1:0] offs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phw_reg  <= '0;
            quad_reg <= '0;
            lin_reg  <= '0;
            offs_reg <= sdfg_pkg::OFFSET_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sdfg_pkg::CFG_PROBE_HALF_WIDTH:  phw_reg  <= cfg_data[sdfg_pkg::PHW_W-1:0];
                sdfg_pkg::CFG_FALLOFF_QUADRATIC: quad_reg <= $signed(cfg_data);
                sdfg_pkg::CFG_FALLOFF_LINEAR:    lin_reg  <= $signed(cfg_data);
                sdfg_pkg::CFG_FALLOFF_OFFSET:    offs_reg <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    // valid bits shift with the data; a full output register that is not taken
    // freezes every stage, so nothing is dropped or repeated
    logic vld_reg [sdfg_pkg::PIPE_STAGES];
    logic en;

    assign en        = !vld_reg[sdfg_pkg::PIPE_STAGES-1] || res.ready;
    assign pos.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < sdfg_pkg::PIPE_STAGES; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= pos.valid;
            for (int i = 1; i < sdfg_pkg::PIPE_STAGES; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // ---------------- stage 1: coordinate differences ----------------
    // edges at x = -e and x = +e; rd is the detector's distance to the edge in x
    logic signed [DW-1:0] e_s, xs_s, ys_s, zs_s, xd_s, yd_s, zd_s;
    logic [MW-1:0] ax1_reg, ax2_reg, az_reg, dy_reg, dx_reg, rd1_reg, rd2_reg;
    logic          ar1_reg;

    assign e_s  = $signed({3'b000, phw_reg});
    assign xs_s = DW'(pos.source_x);
    assign ys_s = DW'(pos.source_y);
    assign zs_s = DW'(pos.source_z);
    assign xd_s = DW'(pos.detector_x);
    assign yd_s = DW'(pos.detector_y);
    assign zd_s = DW'(pos.detector_z);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax1_reg <= sdfg_pkg::mag(-e_s - xs_s);
            ax2_reg <= sdfg_pkg::mag(e_s - xs_s);
            az_reg  <= sdfg_pkg::mag(zd_s - zs_s);
            dy_reg  <= sdfg_pkg::mag(yd_s - ys_s);
            dx_reg  <= sdfg_pkg::mag(xd_s - xs_s);
            rd1_reg <= sdfg_pkg::mag(xd_s + e_s);
            rd2_reg <= sdfg_pkg::mag(xd_s - e_s);
            ar1_reg <= pos.source_z[sdfg_pkg::COORD_W-1];
        end
    end

    // ---------------- stage 2: squares ----------------
    logic [SW-1:0] sq_ax1_reg, sq_ax2_reg, sq_az_reg, sq_dy_reg, sq_dx_reg;
    logic [MW-1:0] rd1_2_reg, rd2_2_reg;
    logic          ar2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_ax1_reg <= SW'(ax1_reg) * SW'(ax1_reg);
            sq_ax2_reg <= SW'(ax2_reg) * SW'(ax2_reg);
            sq_az_reg  <= SW'(az_reg) * SW'(az_reg);
            sq_dy_reg  <= SW'(dy_reg) * SW'(dy_reg);
            sq_dx_reg  <= SW'(dx_reg) * SW'(dx_reg);
            rd1_2_reg  <= rd1_reg;
            rd2_2_reg  <= rd2_reg;
            ar2_reg    <= ar1_reg;
        end
    end

    // ---------------- stage 3: radicands ----------------
    // straight path radicand rides along and replaces the edge radicands later
    logic [RW-1:0] r1_reg, r2_reg;
    sdfg_pkg::sba_t sba3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r1_reg         <= RW'(sq_ax1_reg) + RW'(sq_az_reg);
            r2_reg         <= RW'(sq_ax2_reg) + RW'(sq_az_reg);
            sba3_reg.rstr  <= RW'(sq_dx_reg) + RW'(sq_dy_reg) + RW'(sq_az_reg);
            sba3_reg.sq_dy <= sq_dy_reg;
            sba3_reg.rd1   <= rd1_2_reg;
            sba3_reg.rd2   <= rd2_2_reg;
            sba3_reg.ar    <= ar2_reg;
        end
    end

    // ---------------- first square root: source to edge ----------------
    logic [PW-1:0] rs1, rs2;
    sdfg_pkg::sba_t sba_reg [sdfg_pkg::SQRT_STAGES];

    sdfg_isqrt u_sqrt_rs1 (.clk(clk), .en(en), .rad(r1_reg), .root(rs1));
    sdfg_isqrt u_sqrt_rs2 (.clk(clk), .en(en), .rad(r2_reg), .root(rs2));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sba_reg[0] <= sba3_reg;
            for (int i = 1; i < sdfg_pkg::SQRT_STAGES; i++)
            begin
                sba_reg[i] <= sba_reg[i-1];
            end
        end
    end

    // ---------------- stages 4 to 6: unfolded edge paths ----------------
    sdfg_pkg::sba_t sba_last;
    logic [PW-1:0] sum1_reg, sum2_reg;
    logic [RW-1:0] ssq1_reg, ssq2_reg, rad1_reg, rad2_reg;
    logic [SW-1:0] sq_dy4_reg, sq_dy5_reg;
    logic [RW-1:0] rstr4_reg, rstr5_reg;
    logic          ar4_reg, ar5_reg, ar6_reg;

    assign sba_last = sba_reg[sdfg_pkg::SQRT_STAGES-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum1_reg   <= rs1 + PW'(sba_last.rd1);
            sum2_reg   <= rs2 + PW'(sba_last.rd2);
            sq_dy4_reg <= sba_last.sq_dy;
            rstr4_reg  <= sba_last.rstr;
            ar4_reg    <= sba_last.ar;

            ssq1_reg   <= RW'(sum1_reg) * RW'(sum1_reg);
            ssq2_reg   <= RW'(sum2_reg) * RW'(sum2_reg);
            sq_dy5_reg <= sq_dy4_reg;
            rstr5_reg  <= rstr4_reg;
            ar5_reg    <= ar4_reg;

            rad1_reg   <= ar5_reg ? ssq1_reg + RW'(sq_dy5_reg) : rstr5_reg;
            rad2_reg   <= ar5_reg ? ssq2_reg + RW'(sq_dy5_reg) : rstr5_reg;
            ar6_reg    <= ar5_reg;
        end
    end

    // ---------------- second square root: full path lengths ----------------
    logic [PW-1:0] len1, len2;
    logic          arb_reg [sdfg_pkg::SQRT_STAGES];

    sdfg_isqrt u_sqrt_len1 (.clk(clk), .en(en), .rad(rad1_reg), .root(len1));
    sdfg_isqrt u_sqrt_len2 (.clk(clk), .en(en), .rad(rad2_reg), .root(len2));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            arb_reg[0] <= ar6_reg;
            for (int i = 1; i < sdfg_pkg::SQRT_STAGES; i++)
            begin
                arb_reg[i] <= arb_reg[i-1];
            end
        end
    end

    // ---------------- stages 7 to 11: falloff denominator ----------------
    // N = a*D^2 + b*D*2^F + c*2^2F, D16 = N >> 2F; a*D^2 is split in two halves
    logic [PW-1:0]        d7_reg, d8_reg, d9_reg, d10_reg;
    logic                 ar7_reg, ar8_reg, ar9_reg, ar10_reg;
    logic [RW-1:0]        dsq_reg;
    logic signed [58:0]   ph_reg, pl_reg, pb_reg;
    logic signed [NW-1:0] n_reg;
    logic signed [NW-1:0] n_shift;
    logic [sdfg_pkg::D16_W-1:0] d16;
    sdfg_pkg::divs_t      init_reg;
    sdfg_pkg::divs_t      init_next;

    assign n_shift = n_reg >>> (2 * F);
    assign d16     = n_shift[sdfg_pkg::D16_W-1:0];

    always_comb
    begin
        init_next.rem = sdfg_pkg::DVS_W'(256);
        init_next.q   = '0;
        init_next.dvs = d16[sdfg_pkg::DVS_W-1:0];
        init_next.d   = d10_reg;
        init_next.ar  = ar10_reg;
        // non-positive or at most 256 overflows the gain; 2^41 and above gives zero
        if (d16[sdfg_pkg::D16_W-1] || d16 <= sdfg_pkg::D16_W'(256))
        begin
            init_next.kind = sdfg_pkg::GAIN_FULL;
        end
        else if (|d16[sdfg_pkg::D16_W-1:sdfg_pkg::DVS_W])
        begin
            init_next.kind = sdfg_pkg::GAIN_NONE;
        end
        else
        begin
            init_next.kind = sdfg_pkg::GAIN_QUOT;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d7_reg   <= (len1 < len2) ? len1 : len2;
            ar7_reg  <= arb_reg[sdfg_pkg::SQRT_STAGES-1];

            dsq_reg  <= RW'(d7_reg) * RW'(d7_reg);
            d8_reg   <= d7_reg;
            ar8_reg  <= ar7_reg;

            ph_reg   <= 59'(quad_reg) * 59'($signed({1'b0, dsq_reg[RW-1:RW/2]}));
            pl_reg   <= 59'(quad_reg) * 59'($signed({1'b0, dsq_reg[RW/2-1:0]}));
            pb_reg   <= 59'(lin_reg) * 59'($signed({1'b0, d8_reg}));
            d9_reg   <= d8_reg;
            ar9_reg  <= ar8_reg;

            n_reg    <= (NW'(ph_reg) <<< (RW / 2)) + NW'(pl_reg)
                        + (NW'(pb_reg) <<< F) + (NW'(offs_reg) <<< (2 * F));
            d10_reg  <= d9_reg;
            ar10_reg <= ar9_reg;

            init_reg <= init_next;
        end
    end

    // ---------------- reciprocal divider: 2^40 / D16 ----------------
    // start remainder 2^8 stands for the dividend bits above the 32 quotient bits
    sdfg_pkg::divs_t div_reg  [sdfg_pkg::DIV_STAGES];
    sdfg_pkg::divs_t div_next [sdfg_pkg::DIV_STAGES];
    sdfg_pkg::divs_t div_prev [sdfg_pkg::DIV_STAGES];

    for (genvar s = 0; s < sdfg_pkg::DIV_STAGES; s++)
    begin : g_div
        if (s == 0)
        begin : g_first
            assign div_prev[s] = init_reg;
        end
        else
        begin : g_rest
            assign div_prev[s] = div_reg[s-1];
        end
        assign div_next[s] = sdfg_pkg::div_step(sdfg_pkg::div_step(div_prev[s]));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                div_reg[s] <= div_next[s];
            end
        end
    end

    // ---------------- output register ----------------
    sdfg_pkg::divs_t div_last;
    logic [sdfg_pkg::GAIN_W-1:0] gain_next;
    logic [sdfg_pkg::GAIN_W-1:0] gain_reg;
    logic [PW-1:0]               plen_reg;
    logic                        around_reg;
    logic                        sat_reg;

    assign div_last = div_reg[sdfg_pkg::DIV_STAGES-1];

    always_comb
    begin
        case (div_last.kind)
            sdfg_pkg::GAIN_QUOT: gain_next = div_last.q;
            sdfg_pkg::GAIN_FULL: gain_next = '1;
            default:             gain_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            gain_reg   <= gain_next;
            plen_reg   <= div_last.d;
            around_reg <= div_last.ar;
            sat_reg    <= (div_last.kind == sdfg_pkg::GAIN_FULL);
        end
    end

    assign res.valid        = vld_reg[sdfg_pkg::PIPE_STAGES-1];
    assign res.gain         = gain_reg;
    assign res.path_length  = plen_reg;
    assign res.around_probe = around_reg;
    assign res.saturated    = sat_reg;

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for the source-detector falloff gain core.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES = 64;    // past the full depth of the pipe
    localparam int STALL_LIMIT = 5000;  // cycles with work pending and no item moving
    localparam int QUIET_START = 700;   // window with no idling on either side
    localparam int QUIET_END   = 1200;

    typedef struct {
        logic signed [sdfg_pkg::COORD_W-1:0] xs, ys, zs, xd, yd, zd;
    } pair_t;

    typedef struct {
        logic [sdfg_pkg::GAIN_W-1:0] gain;
        logic [sdfg_pkg::PATH_W-1:0] plen;
        logic                        around;
        logic                        sat;
    } gain_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [sdfg_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [sdfg_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    sdfg_in_if  pos ();
    sdfg_out_if res ();

    source_detector_falloff_gain_core uut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .pos(pos.sink), .res(res.source)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow copy of the configuration registers
    logic [sdfg_pkg::PHW_W-1:0]         half_width = '0;
    logic signed [sdfg_pkg::COEF_W-1:0] coef_a = '0;
    logic signed [sdfg_pkg::COEF_W-1:0] coef_b = '0;
    logic signed [sdfg_pkg::COEF_W-1:0] coef_c = sdfg_pkg::OFFSET_RESET;

    pair_t     pending_pairs[$];
    gain_res_t expected_gains[$];
    int        err_count = 0;
    int        cyc = 0;
    bit        took = 1'b0;

    // floor integer square root
    function automatic logic [63:0] root_floor(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = '0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint absval(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // shortest path touching the edge line at x = e, z = detector_z (unfolded)
    function automatic longint edge_len(input longint e, input pair_t p);
        longint ax, az, dy, rs, rd, s;
        ax = absval(e - p.xs);
        az = absval(longint'(p.zd) - p.zs);
        dy = absval(longint'(p.yd) - p.ys);
        rs = root_floor(ax * ax + az * az);
        rd = absval(p.xd - e);
        s  = rs + rd;
        return root_floor(s * s + dy * dy);
    endfunction

    function automatic gain_res_t predict_gain(input pair_t p);
        gain_res_t r;
        longint dx, dy, dz, d, e, p1, p2;
        logic signed [127:0] ta, tdd, tb, tc, num;
        logic [63:0] q;
        r.sat    = 1'b0;
        r.around = (p.zs < 0);
        if (!r.around)
        begin
            dx = absval(longint'(p.xd) - p.xs);
            dy = absval(longint'(p.yd) - p.ys);
            dz = absval(longint'(p.zd) - p.zs);
            d  = root_floor(dx * dx + dy * dy + dz * dz);
        end
        else
        begin
            e  = longint'(half_width);
            p1 = edge_len(-e, p);
            p2 = edge_len(e, p);
            d  = (p1 < p2) ? p1 : p2;
        end
        if (d > 64'h3FF_FFFF)
        begin
            r.plen = '1;
            r.sat  = 1'b1;
        end
        else
            r.plen = d[sdfg_pkg::PATH_W-1:0];
        // denominator in Q16.16, exact before the final shift
        ta  = longint'(coef_a);
        tdd = d * d;
        tb  = longint'(coef_b) * d;
        tc  = longint'(coef_c);
        num = ta * tdd + (tb <<< sdfg_pkg::COORD_FRAC_BITS)
              + (tc <<< (2 * sdfg_pkg::COORD_FRAC_BITS));
        num = num >>> (2 * sdfg_pkg::COORD_FRAC_BITS);
        if (num <= 0)
        begin
            r.gain = '1;
            r.sat  = 1'b1;
        end
        else if (num[127:64] != 0)
            r.gain = '0;
        else
        begin
            q = (64'd1 << 40) / num[63:0];
            if (q > 64'hFFFF_FFFF)
            begin
                r.gain = '1;
                r.sat  = 1'b1;
            end
            else
                r.gain = q[sdfg_pkg::GAIN_W-1:0];
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        err_count++;
        $display("tb_top: %s mismatch at %0t: got %0h want %0h", what, $time, got, want);
    endtask

    function automatic bit quiet_window();
        return (cyc >= QUIET_START) && (cyc < QUIET_END);
    endfunction

    // driver: payload changes on the falling edge, held until taken
    always @(negedge clk)
    begin
        cyc <= cyc + 1;
        if (!(pos.valid && !took))
        begin
            if (rst_n && pending_pairs.size() != 0 &&
                (quiet_window() || $urandom_range(99) >= 24))
            begin
                pos.valid      <= 1'b1;
                pos.source_x   <= pending_pairs[0].xs;
                pos.source_y   <= pending_pairs[0].ys;
                pos.source_z   <= pending_pairs[0].zs;
                pos.detector_x <= pending_pairs[0].xd;
                pos.detector_y <= pending_pairs[0].yd;
                pos.detector_z <= pending_pairs[0].zd;
            end
            else
                pos.valid <= 1'b0;
        end
        res.ready <= rst_n && (quiet_window() || $urandom_range(99) >= 24);
        took = 1'b0;
    end

    // accept side: predict on the clock edge that takes the item
    always @(posedge clk)
    begin
        if (rst_n && pos.valid && pos.ready)
        begin
            expected_gains.push_back(predict_gain(pending_pairs[0]));
            void'(pending_pairs.pop_front());
            took = 1'b1;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        gain_res_t w;
        if (rst_n && res.valid && res.ready)
        begin
            if (expected_gains.size() == 0)
            begin
                err_count++;
                $display("tb_top: result with nothing expected at %0t", $time);
            end
            else
            begin
                w = expected_gains.pop_front();
                if (res.gain !== w.gain)
                    report_mismatch("gain", 64'(res.gain), 64'(w.gain));
                if (res.path_length !== w.plen)
                    report_mismatch("path_length", 64'(res.path_length), 64'(w.plen));
                if (res.around_probe !== w.around)
                    report_mismatch("around_probe", 64'(res.around_probe), 64'(w.around));
                if (res.saturated !== w.sat)
                    report_mismatch("saturated", 64'(res.saturated), 64'(w.sat));
            end
        end
    end

    // watchdog: only counts while something is still outstanding
    int stall_cnt = 0;
    always @(posedge clk)
    begin
        if ((pos.valid && pos.ready) || (res.valid && res.ready) ||
            (pending_pairs.size() == 0 && expected_gains.size() == 0))
            stall_cnt <= 0;
        else if (stall_cnt >= STALL_LIMIT)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
        else
            stall_cnt <= stall_cnt + 1;
    end

    task automatic write_reg(input sdfg_pkg::cfg_index_t idx,
                             input logic [sdfg_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            sdfg_pkg::CFG_PROBE_HALF_WIDTH:  half_width = val[sdfg_pkg::PHW_W-1:0];
            sdfg_pkg::CFG_FALLOFF_QUADRATIC: coef_a = val;
            sdfg_pkg::CFG_FALLOFF_LINEAR:    coef_b = val;
            default:                         coef_c = val;
        endcase
    endtask

    task automatic load_falloff(input logic [sdfg_pkg::CFG_DATA_W-1:0] hw,
                                input logic [31:0] a,
                                input logic [31:0] b, input logic [31:0] c);
        write_reg(sdfg_pkg::CFG_PROBE_HALF_WIDTH, hw);
        write_reg(sdfg_pkg::CFG_FALLOFF_QUADRATIC, a);
        write_reg(sdfg_pkg::CFG_FALLOFF_LINEAR, b);
        write_reg(sdfg_pkg::CFG_FALLOFF_OFFSET, c);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // hold the sender until the pipe has delivered every expected result
    task automatic drain();
        while (pending_pairs.size() != 0 || expected_gains.size() != 0)
            @(posedge clk);
        repeat (HOLD_CYCLES) @(posedge clk);
    endtask

    function automatic logic signed [sdfg_pkg::COORD_W-1:0] rand_coord(input int span);
        int m;
        m = $urandom_range(3);
        if (m == 0)
            return sdfg_pkg::COORD_W'($urandom());  // full range
        return sdfg_pkg::COORD_W'($signed($urandom_range(2 * span)) - span);
    endfunction

    task automatic push_pair(input logic signed [sdfg_pkg::COORD_W-1:0] xs, ys, zs,
                             xd, yd, zd);
        pair_t p;
        p.xs = xs; p.ys = ys; p.zs = zs;
        p.xd = xd; p.yd = yd; p.zd = zd;
        pending_pairs.push_back(p);
    endtask

    task automatic push_random(input int n, input int span);
        logic signed [sdfg_pkg::COORD_W-1:0] zs;
        repeat (n)
        begin
            zs = rand_coord(span);
            if ($urandom_range(1))
                zs = (zs < 0) ? zs : ~zs;           // at least half go around the probe
            push_pair(rand_coord(span), rand_coord(span), zs,
                      rand_coord(span), rand_coord(span), rand_coord(span));
        end
    endtask

    localparam logic signed [sdfg_pkg::COORD_W-1:0] CMAX = 24'sh7FFFFF;
    localparam logic signed [sdfg_pkg::COORD_W-1:0] CMIN = 24'sh800000;

    initial
    begin
        pos.valid = 1'b0;
        pos.source_x = '0; pos.source_y = '0; pos.source_z = '0;
        pos.detector_x = '0; pos.detector_y = '0; pos.detector_z = '0;
        res.ready = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset values: c = 1.0, so every distance gives the same gain of 2^24
        push_pair('0, '0, '0, '0, '0, '0);
        push_pair('0, '0, '0, 24'sd4096, '0, '0);
        push_pair(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN);
        push_pair(CMIN, CMIN, '0, CMAX, CMAX, CMAX);
        push_pair('0, '0, -24'sd1, '0, '0, '0);
        push_pair(CMIN, CMAX, CMIN, CMAX, CMIN, CMAX);
        push_pair(24'sd100, -24'sd50, -24'sd4096, -24'sd300, 24'sd77, 24'sd0);
        drain();

        // wide probe, pure quadratic: zero distance gives a zero divisor
        load_falloff(32'h7F_FFFF, 32'h0001_0000, 0, 0);
        push_pair('0, '0, '0, '0, '0, '0);
        push_pair('0, '0, -24'sd1, '0, '0, '0);
        push_pair(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
        push_pair(CMAX, '0, -24'sd8192, CMIN, '0, CMAX);
        push_pair(24'sd4096, 24'sd4096, 24'sd4096, '0, '0, '0);
        drain();

        // coefficient extremes: negative and huge denominators
        load_falloff(0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        push_pair('0, '0, '0, '0, '0, '0);
        push_pair(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
        push_pair('0, '0, -24'sd5, 24'sd3, '0, '0);
        drain();
        load_falloff(32'h40_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_pair('0, '0, '0, '0, '0, '0);
        push_pair(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
        push_pair(CMAX, CMIN, -24'sd1, CMIN, CMAX, CMIN);
        drain();

        // random phases with mostly sane falloff coefficients
        for (int ph = 0; ph < 6; ph++)
        begin
            load_falloff($urandom_range(32'h7F_FFFF),
                         (ph % 3 == 0) ? $urandom() : $urandom_range(32'h2_0000),
                         (ph % 3 == 0) ? $urandom() : $urandom_range(32'h4_0000),
                         (ph % 3 == 1) ? $urandom() : $urandom_range(32'h10_0000));
            push_random(90, (ph < 3) ? 65536 : 8000000);
            drain();
        end

        if (err_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
design/sdfg_pkg.sv
design/sdfg_in_if.sv
design/sdfg_out_if.sv
design/sdfg_isqrt.sv
design/source_detector_falloff_gain_core.sv
tb/tb_top.sv
